>>> hdl/ipfmt_pkg.sv
// Package for the IP address text formatter: kind codes, field indexes,
// character codes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipfmt_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V4   = 2'd1,
    KIND_V6   = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SEL_HEAD,
    SEL_SEP2,
    SEL_DIG,
    SEL_LIT,
    SEL_ERR
  } sel_t;

  // field index: 0..7 address groups/octets, then end-of-address "::", prefix, done
  localparam logic [3:0] FLD_ZEND   = 4'd8;
  localparam logic [3:0] FLD_PREFIX = 4'd9;
  localparam logic [3:0] FLD_DONE   = 4'd10;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h57;  // 'a' - 10
  localparam logic [31:0] TXT_NONE = 32'h6e6f6e65;

  typedef struct packed {
    logic       load;
    logic       emit;
    sel_t       sel;
    logic [3:0] fld;
    logic [1:0] dig;
    logic       last;
  } cmd_t;

  typedef struct packed {
    kind_t      in_kind;
    logic [3:0] in_first_fld;
    logic [1:0] sep_cnt;
    logic [1:0] first_dig;
    logic       has_dig;
    logic [3:0] next_fld;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/ipfmt_dp.sv
// Datapath of the IP address text formatter: input registers, zero-run search,
// field and digit selection, character build and output register. Uses ipfmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfmt_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [135:0]      in_data,
  input  wire logic [2:0]        in_user,
  input  wire ipfmt_pkg::cmd_t   cmd,
  output ipfmt_pkg::sts_t        sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_char,
  output logic                   out_last,
  output logic                   out_status
);

  function automatic logic [6:0] zero_run(input logic [7:0] z);
    logic [3:0] run;
    logic [2:0] pos;
    logic [3:0] len;
    run = 4'd0;
    pos = 3'd0;
    len = 4'd0;
    for (int j = 7; j >= 0; j--) begin
      run = z[j] ? run + 4'd1 : 4'd0;
      if (run >= len && run != 4'd0) begin
        pos = 3'(j);
        len = run;
      end
    end
    return {pos, len};
  endfunction

  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [11:0] b;
    b = 12'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[3:0] >= 4'd5) b[3:0] = b[3:0] + 4'd3;
      if (b[7:4] >= 4'd5) b[7:4] = b[7:4] + 4'd3;
      if (b[11:8] >= 4'd5) b[11:8] = b[11:8] + 4'd3;
      b = {b[10:0], v[i]};
    end
    return b;
  endfunction

  logic [127:0]     addr;
  logic [7:0]       prefix;
  logic             show;
  ipfmt_pkg::kind_t kind;
  logic [2:0]       run_pos;
  logic [3:0]       run_len;

  logic [7:0]  in_zero;
  logic [6:0]  in_run;
  logic        run_ok;
  logic [3:0]  run_end;
  logic        is_dec;
  logic [15:0] grp;
  logic [7:0]  dec_val;
  logic [11:0] bcd;
  logic [15:0] dig_src;
  logic [1:0]  dig_idx;
  logic [3:0]  nib;
  logic [7:0]  hex_char;
  logic [7:0]  sep_char;
  logic [7:0]  ch;
  logic [3:0]  fld_inc;
  logic [3:0]  first_fld;
  logic [1:0]  sep_cnt;
  logic [1:0]  first_dig;
  logic [3:0]  next_fld;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      in_zero[g] = (in_data[(g < 4) ? (48 - 16 * g) : (64 + 112 - 16 * g) +: 16] == 16'h0);
    end
    in_run = zero_run(in_zero);
  end

  always_comb begin
    if (in_user[1:0] == ipfmt_pkg::KIND_V6 && in_run[3:0] >= 4'd2 && in_run[6:4] == 3'd0) begin
      first_fld = in_run[3:0];
    end else begin
      first_fld = 4'd0;
    end
  end

  assign run_ok  = (run_len >= 4'd2);
  assign run_end = {1'b0, run_pos} + run_len;
  assign is_dec  = (cmd.fld == ipfmt_pkg::FLD_PREFIX) || (kind == ipfmt_pkg::KIND_V4);
  assign grp     = addr[{3'd7 - cmd.fld[2:0], 4'h0} +: 16];
  assign dec_val = (cmd.fld == ipfmt_pkg::FLD_PREFIX) ? prefix :
                   addr[{2'd3 - cmd.fld[1:0], 3'h0} +: 8];
  assign bcd     = to_bcd(dec_val);
  assign dig_src = is_dec ? {4'h0, bcd} : grp;
  assign fld_inc = cmd.fld + 4'd1;

  always_comb begin
    if (is_dec) begin
      if (bcd[11:8] != 4'h0) first_dig = 2'd2;
      else if (bcd[7:4] != 4'h0) first_dig = 2'd1;
      else first_dig = 2'd0;
    end else begin
      if (grp[15:12] != 4'h0) first_dig = 2'd3;
      else if (grp[11:8] != 4'h0) first_dig = 2'd2;
      else if (grp[7:4] != 4'h0) first_dig = 2'd1;
      else first_dig = 2'd0;
    end
  end

  always_comb begin
    if (cmd.fld == ipfmt_pkg::FLD_PREFIX) begin
      sep_cnt  = 2'd1;
      sep_char = ipfmt_pkg::CH_SLASH;
    end else if (kind == ipfmt_pkg::KIND_V4) begin
      sep_cnt  = (cmd.fld == 4'd0) ? 2'd0 : 2'd1;
      sep_char = ipfmt_pkg::CH_DOT;
    end else if (run_ok && cmd.fld == run_end) begin
      sep_cnt  = 2'd2;
      sep_char = ipfmt_pkg::CH_COLON;
    end else begin
      sep_cnt  = (cmd.fld == 4'd0) ? 2'd0 : 2'd1;
      sep_char = ipfmt_pkg::CH_COLON;
    end
  end

  always_comb begin
    if (cmd.fld == ipfmt_pkg::FLD_PREFIX || cmd.fld == ipfmt_pkg::FLD_DONE) begin
      next_fld = ipfmt_pkg::FLD_DONE;
    end else if (kind == ipfmt_pkg::KIND_V4) begin
      next_fld = (cmd.fld >= 4'd3) ? ipfmt_pkg::FLD_PREFIX : fld_inc;
    end else if (cmd.fld == ipfmt_pkg::FLD_ZEND) begin
      next_fld = ipfmt_pkg::FLD_PREFIX;
    end else if (run_ok && fld_inc == {1'b0, run_pos}) begin
      next_fld = run_end;
    end else if (fld_inc == ipfmt_pkg::FLD_ZEND) begin
      next_fld = ipfmt_pkg::FLD_PREFIX;
    end else begin
      next_fld = fld_inc;
    end
    if (next_fld == ipfmt_pkg::FLD_PREFIX && !show) begin
      next_fld = ipfmt_pkg::FLD_DONE;
    end
  end

  always_comb begin
    sts.in_kind      = ipfmt_pkg::kind_t'(in_user[1:0]);
    sts.in_first_fld = first_fld;
    sts.sep_cnt      = sep_cnt;
    sts.first_dig    = first_dig;
    sts.has_dig      = (cmd.fld != ipfmt_pkg::FLD_ZEND);
    sts.next_fld     = next_fld;
    sts.out_free     = !out_valid || out_ready;
  end

  assign dig_idx  = (cmd.sel == ipfmt_pkg::SEL_HEAD) ? first_dig : cmd.dig;
  assign nib      = dig_src[{dig_idx, 2'b00} +: 4];
  assign hex_char = (nib < 4'd10) ? ipfmt_pkg::CH_ZERO + {4'h0, nib} :
                                    ipfmt_pkg::CH_ALPHA + {4'h0, nib};

  always_comb begin
    unique case (cmd.sel)
      ipfmt_pkg::SEL_HEAD: ch = (sep_cnt != 2'd0) ? sep_char : hex_char;
      ipfmt_pkg::SEL_SEP2: ch = ipfmt_pkg::CH_COLON;
      ipfmt_pkg::SEL_DIG:  ch = hex_char;
      ipfmt_pkg::SEL_LIT:  ch = ipfmt_pkg::TXT_NONE[{2'd3 - cmd.dig, 3'h0} +: 8];
      ipfmt_pkg::SEL_ERR:  ch = 8'h00;
      default:             ch = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr    <= {in_data[63:0], in_data[127:64]};
      prefix  <= in_data[135:128];
      show    <= in_user[2];
      kind    <= ipfmt_pkg::kind_t'(in_user[1:0]);
      run_pos <= in_run[6:4];
      run_len <= in_run[3:0];
    end
    if (cmd.emit) begin
      out_char   <= ch;
      out_last   <= cmd.last;
      out_status <= (cmd.sel == ipfmt_pkg::SEL_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ipfmt_ctrl.sv
// Controller of the IP address text formatter: walks fields, separators and
// digits, one character per cycle when the output slot is free. Uses ipfmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfmt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output ipfmt_pkg::cmd_t      cmd,
  input  wire ipfmt_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SEP2,
    ST_DIG,
    ST_LIT,
    ST_ERR
  } state_t;

  state_t     state;
  logic [3:0] fld;
  logic [1:0] dig;
  logic       fend;
  logic       last;

  always_comb begin
    fend = ((state == ST_HEAD) && sts.sep_cnt == 2'd0 && sts.first_dig == 2'd0) ||
           ((state == ST_SEP2) && !sts.has_dig) ||
           ((state == ST_DIG) && dig == 2'd0);
    last = (fend && sts.next_fld == ipfmt_pkg::FLD_DONE) ||
           ((state == ST_LIT) && dig == 2'd3) ||
           (state == ST_ERR);
  end

  always_comb begin
    cmd.load = in_valid && (state == ST_IDLE);
    cmd.emit = (state != ST_IDLE) && sts.out_free;
    cmd.fld  = fld;
    cmd.dig  = dig;
    cmd.last = last;
    unique case (state)
      ST_HEAD: cmd.sel = ipfmt_pkg::SEL_HEAD;
      ST_SEP2: cmd.sel = ipfmt_pkg::SEL_SEP2;
      ST_DIG:  cmd.sel = ipfmt_pkg::SEL_DIG;
      ST_LIT:  cmd.sel = ipfmt_pkg::SEL_LIT;
      ST_ERR:  cmd.sel = ipfmt_pkg::SEL_ERR;
      ST_IDLE: cmd.sel = ipfmt_pkg::SEL_ERR;
      default: cmd.sel = ipfmt_pkg::SEL_ERR;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fld   <= 4'd0;
      dig   <= 2'd0;
    end else if (state == ST_IDLE) begin
      if (in_valid) begin
        unique case (sts.in_kind)
          ipfmt_pkg::KIND_NONE: begin
            state <= ST_LIT;
            dig   <= 2'd0;
          end
          ipfmt_pkg::KIND_V4, ipfmt_pkg::KIND_V6: begin
            state <= ST_HEAD;
            fld   <= sts.in_first_fld;
          end
          ipfmt_pkg::KIND_BAD: state <= ST_ERR;
          default:             state <= ST_ERR;
        endcase
      end
    end else if (sts.out_free) begin
      if (last) begin
        state <= ST_IDLE;
      end else if (fend) begin
        state <= ST_HEAD;
        fld   <= sts.next_fld;
      end else begin
        unique case (state)
          ST_HEAD: begin
            if (sts.sep_cnt == 2'd2) begin
              state <= ST_SEP2;
            end else if (sts.sep_cnt == 2'd1) begin
              state <= ST_DIG;
              dig   <= sts.first_dig;
            end else begin
              state <= ST_DIG;
              dig   <= sts.first_dig - 2'd1;
            end
          end
          ST_SEP2: begin
            state <= ST_DIG;
            dig   <= sts.first_dig;
          end
          ST_DIG:  dig <= dig - 2'd1;
          ST_LIT:  dig <= dig + 2'd1;
          ST_ERR:  state <= ST_IDLE;
          ST_IDLE: state <= ST_IDLE;
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/ip_address_text_formatter.sv
// Top level of the IP address text formatter: controller plus datapath.
// Depends on ipfmt_pkg, ipfmt_ctrl and ipfmt_dp.
//
// Usage:
//   The slave stream takes one address item; the master stream returns its
//   ASCII text, one character per item, tlast on the final character.
//   Kind none gives "none", IPv4 dotted decimal, IPv6 compressed hex with
//   an optional "/prefix"; an unsupported kind gives one item, data zero,
//   tuser set.
//   s_axis_tready is high only between addresses. The accept cycle also runs
//   the zero-run search and loads the input registers; the characters are
//   then built and registered one per cycle while the output slot is free.
//   The rate is set by the text length: the sequencer takes the next address
//   only after the last character of the current one.
//   When m_axis_tready is low the current character holds and the sequencer
//   stops. Synchronous reset drops any text in flight and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module ip_address_text_formatter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // address_high, address_low, prefix_length
  input  wire logic [2:0]   s_axis_tuser,  // address_kind, show_prefix
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // text_char
  output logic              m_axis_tlast,
  output logic [0:0]        m_axis_tuser   // status
);

  ipfmt_pkg::cmd_t cmd;
  ipfmt_pkg::sts_t sts;

  ipfmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ipfmt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_axis_tdata),
    .in_user    (s_axis_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_status (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

>>> tb/ipfmt_text_checker.sv
// Checker for the IP address text formatter: watches both streams, predicts the text of
// each accepted address and compares every character item against it.
// Depends on ipfmt_pkg.
`timescale 1ns / 1ps

module ipfmt_text_checker
  import ipfmt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // address_high, address_low, prefix_length
  input  wire logic [2:0]   s_axis_tuser,  // address_kind, show_prefix
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [7:0]   m_axis_tdata,  // text_char
  input  wire logic         m_axis_tlast,
  input  wire logic [0:0]   m_axis_tuser,  // status
  output int                mismatch_count,
  output int                chars_checked,
  output int                pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       status;
  } text_item_t;

  text_item_t expected_text[$];
  logic [7:0] text_q[$];

  function automatic void put_dec(input logic [7:0] v);
    if (v >= 8'd100) text_q.push_back(CH_ZERO + 8'(v / 8'd100));
    if (v >= 8'd10) text_q.push_back(CH_ZERO + 8'((v / 8'd10) % 8'd10));
    text_q.push_back(CH_ZERO + 8'(v % 8'd10));
  endfunction

  function automatic void put_hex_group(input logic [15:0] v);
    logic       started;
    logic [3:0] d;
    started = 1'b0;
    for (int s = 3; s >= 0; s--) begin
      d = v[s*4 +: 4];
      if (d != 4'd0 || started || s == 0) begin
        text_q.push_back(d < 4'd10 ? CH_ZERO + 8'(d) : CH_ALPHA + 8'(d));
        started = 1'b1;
      end
    end
  endfunction

  function automatic void predict_text(input kind_t kind, input logic [63:0] hi,
                                       input logic [63:0] lo, input logic [7:0] pfx,
                                       input logic show);
    logic [15:0] grp[8];
    int          run;
    int          best_pos;
    int          best_len;
    int          g;
    text_q.delete();
    if (kind == KIND_BAD) begin
      expected_text.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    if (kind == KIND_NONE) begin
      for (int k = 3; k >= 0; k--) text_q.push_back(TXT_NONE[k*8 +: 8]);
    end else begin
      if (kind == KIND_V4) begin
        put_dec(lo[31:24]);
        text_q.push_back(CH_DOT);
        put_dec(lo[23:16]);
        text_q.push_back(CH_DOT);
        put_dec(lo[15:8]);
        text_q.push_back(CH_DOT);
        put_dec(lo[7:0]);
      end else begin
        for (int k = 0; k < 4; k++) begin
          grp[k]     = hi[63 - 16*k -: 16];
          grp[k + 4] = lo[63 - 16*k -: 16];
        end
        // scan backwards so a tie keeps the first run
        run = 0;
        best_pos = 8;
        best_len = 0;
        for (int k = 7; k >= 0; k--) begin
          run = (grp[k] == 16'd0) ? run + 1 : 0;
          if (run >= best_len && run > 0) begin
            best_pos = k;
            best_len = run;
          end
        end
        if (best_len < 2) best_pos = 8;
        g = 0;
        while (g < 8) begin
          if (g == best_pos) begin
            text_q.push_back(CH_COLON);
            text_q.push_back(CH_COLON);
            g += best_len;
            if (g < 8) begin
              put_hex_group(grp[g]);
              g++;
            end
          end else begin
            if (g != 0) text_q.push_back(CH_COLON);
            put_hex_group(grp[g]);
            g++;
          end
        end
      end
      if (show) begin
        text_q.push_back(CH_SLASH);
        put_dec(pfx);
      end
    end
    foreach (text_q[k]) expected_text.push_back('{text_q[k], k == text_q.size() - 1, 1'b0});
  endfunction

  initial begin
    mismatch_count = 0;
    chars_checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    text_item_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_text(kind_t'(s_axis_tuser[1:0]), s_axis_tdata[63:0], s_axis_tdata[127:64],
                     s_axis_tdata[135:128], s_axis_tuser[2]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected item: char %h last %b status %b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== m_axis_tdata || want.last !== m_axis_tlast ||
              want.status !== m_axis_tuser[0]) begin
            $display("%0t: mismatch: expected char %h last %b status %b, got char %h last %b status %b",
                     $time, want.ch, want.last, want.status,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            mismatch_count <= mismatch_count + 1;
          end
          chars_checked <= chars_checked + 1;
        end
      end
      pending <= expected_text.size();
    end
  end

endmodule

>>> tb/ip_address_text_formatter_tb.sv
// Top of the IP address text formatter testbench: clock, reset, address stimulus with
// sender gaps and receiver stalls, and the verdict.
// Depends on ipfmt_pkg, ip_address_text_formatter and ipfmt_text_checker.
`timescale 1ns / 1ps

module ip_address_text_formatter_tb;
  import ipfmt_pkg::*;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;
  logic [0:0]   m_axis_tuser;

  int mismatch_count;
  int chars_checked;
  int pending;
  int gap_pct;
  int stall_pct;
  int hold_cycles_req;
  int directed_sent;
  int random_sent;

  always #2 clk = ~clk;

  ip_address_text_formatter u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  ipfmt_text_checker u_text_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatch_count(mismatch_count),
    .chars_checked (chars_checked),
    .pending       (pending)
  );

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        hold = hold_cycles_req;
        hold_cycles_req = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #4000000;
    $display("Timeout at %0t with %0d characters outstanding", $time, pending);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_address(input kind_t kind, input logic [63:0] hi, input logic [63:0] lo,
                              input logic [7:0] pfx, input logic show);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pfx, lo, hi};
    s_axis_tuser  <= {show, kind};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'd0;
      3:       return 16'($urandom_range(1, 15));
      default: return 16'($urandom) >> $urandom_range(0, 12);
    endcase
  endfunction

  task automatic send_random_addresses(input int count);
    kind_t       kind;
    logic [63:0] hi;
    logic [63:0] lo;
    int          r;
    repeat (count) begin
      r = $urandom_range(99);
      kind = r < 6 ? KIND_NONE : r < 11 ? KIND_BAD : r < 45 ? KIND_V4 : KIND_V6;
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if (kind == KIND_V6 && $urandom_range(3) != 0) begin
        for (int k = 0; k < 4; k++) begin
          hi[63 - 16*k -: 16] = rand_group();
          lo[63 - 16*k -: 16] = rand_group();
        end
      end
      if (kind == KIND_V4 && $urandom_range(1) == 1) begin
        for (int k = 0; k < 4; k++) lo[k*8 +: 8] = 8'($urandom_range(255) >> $urandom_range(7));
      end
      send_address(kind, hi, lo, 8'($urandom_range(255) >> $urandom_range(7)), 1'($urandom));
      random_sent++;
    end
  endtask

  task automatic send_directed(input kind_t kind, input logic [63:0] hi, input logic [63:0] lo,
                               input logic [7:0] pfx, input logic show);
    send_address(kind, hi, lo, pfx, show);
    directed_sent++;
  endtask

  initial begin
    directed_sent = 0;
    random_sent = 0;
    hold_cycles_req = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_directed(KIND_NONE, '1, '1, 8'd255, 1'b1);
    send_directed(KIND_NONE, '0, '0, 8'd0, 1'b0);
    send_directed(KIND_BAD, '1, '1, 8'd255, 1'b1);
    send_directed(KIND_BAD, '0, '0, 8'd0, 1'b0);
    send_directed(KIND_V4, '0, '0, 8'd0, 1'b1);
    send_directed(KIND_V4, '1, '1, 8'd255, 1'b1);
    send_directed(KIND_V4, 64'hdead_beef_0123_4567, 64'hffff_ffff_0a01_6409, 8'd32, 1'b1);
    send_directed(KIND_V4, '0, 64'h0000_0000_0116_8504, 8'd9, 1'b0);
    send_directed(KIND_V4, '0, 64'h0000_0000_c0a8_0001, 8'd10, 1'b1);
    send_directed(KIND_V6, '0, '0, 8'd0, 1'b0);
    send_directed(KIND_V6, '0, '0, 8'd128, 1'b1);
    send_directed(KIND_V6, '1, '1, 8'd255, 1'b1);
    send_directed(KIND_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd64, 1'b1);
    send_directed(KIND_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd99, 1'b1);
    send_directed(KIND_V6, 64'h0000_0000_0000_0001, 64'h0002_0003_0004_0005, 8'd100, 1'b1);
    send_directed(KIND_V6, 64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000, 8'd1, 1'b1);
    send_directed(KIND_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003, 8'd0, 1'b0);
    send_directed(KIND_V6, 64'h0001_0010_0100_1000, 64'habcd_0ef0_00f0_000f, 8'd48, 1'b0);
    send_directed(KIND_V6, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000, 8'd127, 1'b1);
    send_directed(KIND_V6, 64'h0000_0001_0002_0003, 64'h0004_0005_0006_0007, 8'd200, 1'b1);
    send_directed(KIND_V6, 64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0001, 8'd10, 1'b1);
    send_directed(KIND_V6, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 8'd128, 1'b0);

    send_random_addresses(125);
    gap_pct = 83;
    send_random_addresses(125);
    gap_pct = 0;
    stall_pct = 83;
    send_random_addresses(125);
    // long receiver hold while the sender keeps offering items
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles_req = 400;
    send_random_addresses(15);
    gap_pct = 35;
    stall_pct = 35;
    send_random_addresses(110);
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d directed and %0d random addresses through four idling mixes",
             directed_sent, random_sent);
    $display("Checked %0d text characters, %0d mismatches", chars_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
